// File: rtl/ssst_pkg.sv
// ----------------------------------------------------------------------------
// ssst_pkg
// Shared types, constants and fixed-point helpers for the sphere sweep test.
// ----------------------------------------------------------------------------
package ssst_pkg;

    localparam int FRAC_BITS = 16;
    localparam int ACC_W     = 70;
    localparam int MW        = 34;
    localparam int DVD_W     = 32 + FRAC_BITS;
    localparam int CNT_W     = $clog2(DVD_W);
    localparam int IN_W      = 224;
    localparam int OUT_W     = 224;

    localparam longint EPS_RAW = ((64'd1 << FRAC_BITS) + 64'd500) / 64'd1000;
    localparam longint EPS_SQ  = EPS_RAW * EPS_RAW;

    localparam logic signed [31:0] Q_MAX = 32'sh7fffffff;
    localparam logic signed [31:0] Q_MIN = 32'sh80000000;
    localparam logic [30:0]        STEP_RESET = 31'd1092;

    typedef enum logic [5:0] {
        S_IDLE, S_PREP,
        S_D_MUL, S_D_SAT, S_D_SQ, S_D_ACC, S_RAY,
        S_S_MUL, S_S_ACC, S_S_RR, S_S_CMP,
        S_A_MUL, S_A_ACC, S_B_MUL, S_B_ACC, S_C_MUL, S_C_ACC,
        S_RR_MUL, S_C_SUB, S_BB_MUL, S_BB_SAT, S_AC_MUL, S_DELTA,
        S_SQRT, S_DIV, S_T0, S_T1, S_TCHK,
        S_N_MUL0, S_N_MUL1, S_N_ACC, S_L_MUL, S_L_ACC,
        S_U_START, S_U_SETUP, S_U_FIN,
        S_CA_MUL, S_CB_MUL, S_CB_FIN,
        S_HIT, S_MISS
    } t_state;

    function automatic logic signed [31:0] f_sat32(input logic signed [ACC_W-1:0] v);
        if (v > ACC_W'(Q_MAX)) begin
            return Q_MAX;
        end else if (v < ACC_W'(Q_MIN)) begin
            return Q_MIN;
        end
        return v[31:0];
    endfunction

    function automatic logic signed [31:0] f_qadd(input logic signed [31:0] a,
                                                  input logic signed [31:0] b);
        return f_sat32(ACC_W'(a) + ACC_W'(b));
    endfunction

    function automatic logic signed [31:0] f_qsub(input logic signed [31:0] a,
                                                  input logic signed [31:0] b);
        return f_sat32(ACC_W'(a) - ACC_W'(b));
    endfunction

    function automatic logic [31:0] f_mag32(input logic signed [31:0] x);
        return x[31] ? 32'(-x) : x;
    endfunction

endpackage

// File: rtl/sphere_sphere_sweep_test_core.sv
// ----------------------------------------------------------------------------
// sphere_sphere_sweep_test_core
// Continuous collision test of two moving spheres within one time step.
// ----------------------------------------------------------------------------
// Items with tuser = 0 store a first sphere and give no result.
// Items with tuser = 1 are swept against the stored sphere and give one
// result. A test is worked through by one shared 34x34 multiplier, a
// bit-serial divider (32 + FRAC_BITS steps per quotient) and a two-bit-a-step
// root unit (32 steps) under one sequencer on Q16.16 operands. Most of the
// time of a test with a hit goes to the divider, and a miss can end sooner.
// The input is not ready while a test runs; the result waits in an output
// register.
// ----------------------------------------------------------------------------
module sphere_sphere_sweep_test_core (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [30:0]               i_cfg_data,     // step_time
    input  logic                      s_axis_tvalid,
    output logic                      s_axis_tready,
    // pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, radius, pad
    input  logic [ssst_pkg::IN_W-1:0] s_axis_tdata,
    input  logic                      s_axis_tuser,   // second_body
    output logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    // impact_time, contact_a_x/y/z, contact_b_x/y/z, pad
    output logic [ssst_pkg::OUT_W-1:0] m_axis_tdata,
    output logic                      m_axis_tuser    // hit
);
    import ssst_pkg::*;

    t_state r_st, n_st, r_ret;

    logic [30:0] r_step;
    logic        r_fv;
    logic signed [31:0] r_p0 [3];
    logic signed [31:0] r_v0 [3];
    logic [30:0]        r_r0;
    logic signed [31:0] r_p1 [3];
    logic signed [31:0] r_v1 [3];
    logic [30:0]        r_r1;
    logic signed [31:0] r_w [3];
    logic signed [31:0] r_dd [3];
    logic signed [31:0] r_n0 [3];
    logic signed [31:0] r_n1 [3];
    logic signed [31:0] r_diff [3];
    logic signed [31:0] r_u [3];
    logic signed [31:0] r_ca [3];
    logic signed [31:0] r_cb [3];
    logic signed [31:0] r_tmp, r_a, r_b, r_c, r_s, r_t0, r_toi;
    logic [31:0]        r_len;
    logic [1:0]         r_idx;
    logic signed [ACC_W-1:0] r_acc;
    logic signed [2*MW-1:0]  r_prod;

    logic [DVD_W-1:0] r_dvd, r_quo;
    logic [31:0]      r_dvs, r_drem;
    logic             r_qneg, r_nneg, r_nzero;
    logic [63:0]      r_rad;
    logic [33:0]      r_srem;
    logic [31:0]      r_root;
    logic [CNT_W-1:0] r_cnt;

    logic              r_ovalid, r_ohit;
    logic [30:0]       r_otoi;
    logic signed [31:0] r_oca [3];
    logic signed [31:0] r_ocb [3];

    logic signed [MW-1:0] m_a, m_b;
    logic signed [31:0]   w_dn;
    logic [31:0]          w_dvs;
    logic                 w_dneg;

    logic                 w_in_acc, w_out_free;
    logic signed [31:0]   w_prod_q, w_delta, w_rq, w_dres, w_toi, w_n1;
    logic signed [ACC_W-1:0] w_acc_t, w_acc_s;
    logic [32:0]          w_rsum;
    logic                 w_tmiss;
    logic [35:0]          w_srem_sh, w_trial, w_sdiff;
    logic                 w_sge;
    logic [32:0]          w_drem_sh, w_ddiff;
    logic                 w_dge;

    assign o_cfg_ready = 1'b1;
    assign w_in_acc    = s_axis_tvalid && s_axis_tready;
    assign w_out_free  = !r_ovalid || m_axis_tready;

    assign w_prod_q = f_sat32(ACC_W'(r_prod >>> FRAC_BITS));
    assign w_acc_t  = r_acc + ACC_W'(r_prod >>> FRAC_BITS);
    assign w_acc_s  = r_acc + ACC_W'(r_prod);
    assign w_delta  = f_qsub(r_tmp, w_prod_q);
    assign w_rsum   = {2'b00, r_r0} + {2'b00, r_r1};
    assign w_rq     = (w_rsum > 33'h07fffffff) ? Q_MAX : w_rsum[31:0];
    assign w_n1     = f_qadd(r_p1[r_idx], w_prod_q);

    assign w_srem_sh = {r_srem, r_rad[63:62]};
    assign w_trial   = {2'b00, r_root, 2'b01};
    assign w_sge     = w_srem_sh >= w_trial;
    assign w_sdiff   = w_srem_sh - w_trial;

    assign w_drem_sh = {r_drem, r_dvd[DVD_W-1]};
    assign w_dge     = w_drem_sh >= {1'b0, r_dvs};
    assign w_ddiff   = w_drem_sh - {1'b0, r_dvs};

    always_comb begin
        if (r_dvs == '0) begin
            w_dres = r_nzero ? '0 : (r_nneg ? Q_MIN : Q_MAX);
        end else if (r_qneg) begin
            w_dres = (r_quo > DVD_W'(33'h080000000)) ? Q_MIN : 32'(-r_quo[31:0]);
        end else begin
            w_dres = (r_quo > DVD_W'(32'h7fffffff)) ? Q_MAX : r_quo[31:0];
        end
    end

    assign w_toi   = r_t0[31] ? '0 : r_t0;
    assign w_tmiss = w_dres[31] || (w_toi > $signed({1'b0, r_step}));

    // next state
    always_comb begin
        n_st = r_st;
        case (r_st)
            S_IDLE:    if (w_in_acc && s_axis_tuser) n_st = r_fv ? S_PREP : S_MISS;
            S_PREP:    n_st = S_D_MUL;
            S_D_MUL:   n_st = S_D_SAT;
            S_D_SAT:   n_st = S_D_SQ;
            S_D_SQ:    n_st = S_D_ACC;
            S_D_ACC:   n_st = (r_idx == 2'd2) ? S_RAY : S_D_MUL;
            S_RAY:     n_st = (r_acc < ACC_W'(EPS_SQ)) ? S_S_MUL : S_A_MUL;
            S_S_MUL:   n_st = S_S_ACC;
            S_S_ACC:   n_st = (r_idx == 2'd2) ? S_S_RR : S_S_MUL;
            S_S_RR:    n_st = S_S_CMP;
            S_S_CMP:   n_st = (r_acc > ACC_W'(r_prod)) ? S_MISS : S_N_MUL0;
            S_A_MUL:   n_st = S_A_ACC;
            S_A_ACC:   n_st = (r_idx == 2'd2) ? S_B_MUL : S_A_MUL;
            S_B_MUL:   n_st = S_B_ACC;
            S_B_ACC:   n_st = (r_idx == 2'd2) ? S_C_MUL : S_B_MUL;
            S_C_MUL:   n_st = S_C_ACC;
            S_C_ACC:   n_st = (r_idx == 2'd2) ? S_RR_MUL : S_C_MUL;
            S_RR_MUL:  n_st = S_C_SUB;
            S_C_SUB:   n_st = S_BB_MUL;
            S_BB_MUL:  n_st = S_BB_SAT;
            S_BB_SAT:  n_st = S_AC_MUL;
            S_AC_MUL:  n_st = S_DELTA;
            S_DELTA:   n_st = w_delta[31] ? S_MISS : S_SQRT;
            S_SQRT:    if (r_cnt == '0) n_st = r_ret;
            S_DIV:     if (r_cnt == '0) n_st = r_ret;
            S_T0:      n_st = S_DIV;
            S_T1:      n_st = S_DIV;
            S_TCHK:    n_st = w_tmiss ? S_MISS : S_N_MUL0;
            S_N_MUL0:  n_st = S_N_MUL1;
            S_N_MUL1:  n_st = S_N_ACC;
            S_N_ACC:   n_st = (r_idx == 2'd2) ? S_L_MUL : S_N_MUL0;
            S_L_MUL:   n_st = S_L_ACC;
            S_L_ACC:   n_st = (r_idx == 2'd2) ? S_SQRT : S_L_MUL;
            S_U_START: n_st = S_U_SETUP;
            S_U_SETUP: n_st = S_DIV;
            S_U_FIN:   n_st = (r_idx == 2'd2) ? S_CA_MUL : S_U_SETUP;
            S_CA_MUL:  n_st = S_CB_MUL;
            S_CB_MUL:  n_st = S_CB_FIN;
            S_CB_FIN:  n_st = (r_idx == 2'd2) ? S_HIT : S_CA_MUL;
            S_HIT:     if (w_out_free) n_st = S_IDLE;
            S_MISS:    if (w_out_free) n_st = S_IDLE;
            default:   n_st = S_IDLE;
        endcase
    end

    // outputs: handshake, multiplier operands, divider operands
    always_comb begin
        s_axis_tready = (r_st == S_IDLE);
        m_a    = '0;
        m_b    = '0;
        w_dn   = '0;
        w_dvs  = f_mag32(r_a);
        w_dneg = r_a[31];
        case (r_st)
            S_D_MUL:  begin m_a = MW'(r_w[r_idx]);  m_b = MW'({1'b0, r_step}); end
            S_D_SQ:   begin m_a = MW'(r_tmp);       m_b = MW'(r_tmp); end
            S_S_MUL:  begin m_a = MW'(r_dd[r_idx]); m_b = MW'(r_dd[r_idx]); end
            S_S_RR:   begin m_a = {1'b0, w_rsum};   m_b = {1'b0, w_rsum}; end
            S_A_MUL:  begin m_a = MW'(r_w[r_idx]);  m_b = MW'(r_w[r_idx]); end
            S_B_MUL:  begin m_a = MW'(r_dd[r_idx]); m_b = MW'(r_w[r_idx]); end
            S_C_MUL:  begin m_a = MW'(r_dd[r_idx]); m_b = MW'(r_dd[r_idx]); end
            S_RR_MUL: begin m_a = MW'(w_rq);        m_b = MW'(w_rq); end
            S_BB_MUL: begin m_a = MW'(r_b);         m_b = MW'(r_b); end
            S_AC_MUL: begin m_a = MW'(r_a);         m_b = MW'(r_c); end
            S_N_MUL0: begin m_a = MW'(r_v0[r_idx]); m_b = MW'(w_toi); end
            S_N_MUL1: begin m_a = MW'(r_v1[r_idx]); m_b = MW'(w_toi); end
            S_L_MUL:  begin m_a = MW'(r_diff[r_idx]); m_b = MW'(r_diff[r_idx]); end
            S_CA_MUL: begin m_a = MW'(r_u[r_idx]);  m_b = MW'({1'b0, r_r0}); end
            S_CB_MUL: begin m_a = MW'(r_u[r_idx]);  m_b = MW'({1'b0, r_r1}); end
            S_T0:     w_dn = f_qsub(r_b, $signed(r_root));
            S_T1:     w_dn = f_qadd(r_b, r_s);
            S_U_SETUP: begin
                w_dn   = r_diff[r_idx];
                w_dvs  = r_len;
                w_dneg = 1'b0;
            end
            default: ;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st     <= S_IDLE;
            r_fv     <= 1'b0;
            r_ovalid <= 1'b0;
            r_step   <= STEP_RESET;
        end else begin
            r_st <= n_st;
            if (i_cfg_valid && o_cfg_ready) r_step <= i_cfg_data;
            if (w_in_acc && !s_axis_tuser) r_fv <= 1'b1;
            if (m_axis_tvalid && m_axis_tready) r_ovalid <= 1'b0;
            if ((r_st == S_HIT || r_st == S_MISS) && w_out_free) r_ovalid <= 1'b1;
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        r_prod <= m_a * m_b;
        if (r_st == S_T0 || r_st == S_T1 || r_st == S_U_SETUP) begin
            r_dvd   <= {f_mag32(w_dn), FRAC_BITS'(0)};
            r_dvs   <= w_dvs;
            r_qneg  <= w_dn[31] ^ w_dneg;
            r_nneg  <= w_dn[31];
            r_nzero <= (w_dn == '0);
            r_drem  <= '0;
            r_quo   <= '0;
            r_cnt   <= CNT_W'(DVD_W - 1);
        end
        case (r_st)
            S_IDLE: begin
                if (w_in_acc) begin
                    for (int i = 0; i < 3; i++) begin
                        if (s_axis_tuser) begin
                            r_p1[i] <= s_axis_tdata[32*i +: 32];
                            r_v1[i] <= s_axis_tdata[96 + 32*i +: 32];
                        end else begin
                            r_p0[i] <= s_axis_tdata[32*i +: 32];
                            r_v0[i] <= s_axis_tdata[96 + 32*i +: 32];
                        end
                    end
                    if (s_axis_tuser) r_r1 <= s_axis_tdata[222:192];
                    else              r_r0 <= s_axis_tdata[222:192];
                end
            end
            S_PREP: begin
                for (int i = 0; i < 3; i++) begin
                    r_w[i]  <= f_qsub(r_v0[i], r_v1[i]);
                    r_dd[i] <= f_qsub(r_p1[i], r_p0[i]);
                end
                r_idx <= '0;
                r_acc <= '0;
            end
            S_D_SAT: r_tmp <= w_prod_q;
            S_D_ACC, S_S_ACC, S_L_ACC: begin
                r_acc <= w_acc_s;
                r_idx <= (r_idx == 2'd2) ? 2'd0 : r_idx + 2'd1;
                if (r_st == S_L_ACC && r_idx == 2'd2) begin
                    r_rad  <= w_acc_s[63:0];
                    r_srem <= '0;
                    r_root <= '0;
                    r_cnt  <= CNT_W'(31);
                    r_ret  <= S_U_START;
                end
            end
            S_RAY: r_acc <= '0;
            S_S_CMP: begin
                r_t0  <= '0;
                r_toi <= '0;
            end
            S_A_ACC, S_B_ACC, S_C_ACC: begin
                if (r_idx == 2'd2) begin
                    r_acc <= '0;
                    r_idx <= '0;
                    if (r_st == S_A_ACC) r_a <= f_sat32(w_acc_t);
                    if (r_st == S_B_ACC) r_b <= f_sat32(w_acc_t);
                    if (r_st == S_C_ACC) r_tmp <= f_sat32(w_acc_t);
                end else begin
                    r_acc <= w_acc_t;
                    r_idx <= r_idx + 2'd1;
                end
            end
            S_C_SUB:  r_c <= f_qsub(r_tmp, w_prod_q);
            S_BB_SAT: r_tmp <= w_prod_q;
            S_DELTA: begin
                r_rad  <= 64'(w_delta[30:0]) << FRAC_BITS;
                r_srem <= '0;
                r_root <= '0;
                r_cnt  <= CNT_W'(31);
                r_ret  <= S_T0;
            end
            S_SQRT: begin
                r_srem <= w_sge ? w_sdiff[33:0] : w_srem_sh[33:0];
                r_root <= {r_root[30:0], w_sge};
                r_rad  <= {r_rad[61:0], 2'b00};
                r_cnt  <= r_cnt - 1'b1;
            end
            S_DIV: begin
                r_drem <= w_dge ? w_ddiff[31:0] : w_drem_sh[31:0];
                r_quo  <= {r_quo[DVD_W-2:0], w_dge};
                r_dvd  <= {r_dvd[DVD_W-2:0], 1'b0};
                r_cnt  <= r_cnt - 1'b1;
            end
            S_T0: begin
                r_s   <= $signed(r_root);
                r_ret <= S_T1;
            end
            S_T1: begin
                r_t0  <= w_dres;
                r_ret <= S_TCHK;
            end
            S_TCHK: begin
                r_toi <= w_toi;
                r_idx <= '0;
            end
            S_N_MUL1: r_n0[r_idx] <= f_qadd(r_p0[r_idx], w_prod_q);
            S_N_ACC: begin
                r_n1[r_idx]   <= w_n1;
                r_diff[r_idx] <= f_qsub(w_n1, r_n0[r_idx]);
                r_idx <= (r_idx == 2'd2) ? 2'd0 : r_idx + 2'd1;
                r_acc <= '0;
            end
            S_U_START: begin
                r_len <= r_root;
                r_idx <= '0;
            end
            S_U_SETUP: r_ret <= S_U_FIN;
            S_U_FIN: begin
                r_u[r_idx] <= (r_len == '0) ? '0 : w_dres;
                r_idx <= (r_idx == 2'd2) ? 2'd0 : r_idx + 2'd1;
            end
            S_CB_MUL: r_ca[r_idx] <= f_qadd(r_n0[r_idx], w_prod_q);
            S_CB_FIN: begin
                r_cb[r_idx] <= f_qsub(r_n1[r_idx], w_prod_q);
                r_idx <= (r_idx == 2'd2) ? 2'd0 : r_idx + 2'd1;
            end
            S_HIT: begin
                if (w_out_free) begin
                    r_ohit <= 1'b1;
                    r_otoi <= r_toi[30:0];
                    for (int i = 0; i < 3; i++) begin
                        r_oca[i] <= r_ca[i];
                        r_ocb[i] <= r_cb[i];
                    end
                end
            end
            S_MISS: begin
                if (w_out_free) begin
                    r_ohit <= 1'b0;
                    r_otoi <= '0;
                    for (int i = 0; i < 3; i++) begin
                        r_oca[i] <= '0;
                        r_ocb[i] <= '0;
                    end
                end
            end
            default: ;
        endcase
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tuser  = r_ohit;
    assign m_axis_tdata  = {1'b0, r_ocb[2], r_ocb[1], r_ocb[0],
                            r_oca[2], r_oca[1], r_oca[0], r_otoi};

endmodule
